// ----- rtl/core/reed_solomon_systematic_encoder_macros.svh -----
// assertion macros for the reed-solomon systematic encoder
// no dependencies; included by the top level only
`ifndef REED_SOLOMON_SYSTEMATIC_ENCODER_MACROS_SVH
`define REED_SOLOMON_SYSTEMATIC_ENCODER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RSE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rse assertion failed");
`define RSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rse assertion failed");
`else
`define RSE_ASSERT_SAME(label, clk, rst, ante, cons)
`define RSE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/rse_pkg.sv -----
// shared types, constants and field arithmetic for the reed-solomon encoder
// no dependencies
`timescale 1ns / 1ps

package rse_pkg;

   localparam int SYM_BITS = 8;
   localparam int T_MAX    = 16;
   localparam int NPAR     = 2 * T_MAX;
   localparam int CNT_BITS = $clog2(NPAR + 1);
   localparam int CAP_W    = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_ECC_CAP    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_POLY = 2'd1;

   typedef logic [SYM_BITS-1:0] sym_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INIT,
      CELL_STEP,
      CELL_ENCODE,
      CELL_SHIFT
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      sym_type     fb;
      sym_type     root;
      sym_type     poly;
   } cell_ctrl_type;

   typedef struct packed {
      sym_type symbol;
      logic    last;
   } code_type;

   function automatic sym_type gf_xtime(sym_type a, sym_type poly);
      return {a[SYM_BITS-2:0], 1'b0} ^ (a[SYM_BITS-1] ? poly : '0);
   endfunction

   function automatic sym_type gf_mul(sym_type a, sym_type b, sym_type poly);
      sym_type acc;
      sym_type aa;
      acc = '0;
      aa  = a;
      for (int i = 0; i < SYM_BITS; i++) begin
         if (b[i]) acc = acc ^ aa;
         aa = gf_xtime(aa, poly);
      end
      return acc;
   endfunction

endpackage

// ----- rtl/core/rse_cell.sv -----
// one parity cell: holds one parity symbol and one generator coefficient
// depends on rse_pkg
`timescale 1ns / 1ps

module rse_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  rse_pkg::cell_ctrl_type ctrl,
   input  logic                   init_one,
   input  rse_pkg::sym_type       nb_parity,
   input  rse_pkg::sym_type       nb_gen,
   output rse_pkg::sym_type       parity,
   output rse_pkg::sym_type       gen
);
   import rse_pkg::*;

   sym_type parity_ff;
   sym_type parity_in;
   sym_type gen_ff;
   sym_type gen_in;
   sym_type mul_a;
   sym_type prod;

   always_comb begin
      mul_a     = (ctrl.op == CELL_STEP) ? ctrl.root : ctrl.fb;
      prod      = gf_mul(mul_a, gen_ff, ctrl.poly);
      parity_in = parity_ff;
      gen_in    = gen_ff;
      case (ctrl.op)
         CELL_INIT: begin
            gen_in = init_one ? sym_type'(1) : '0;
         end
         CELL_STEP: begin
            gen_in = nb_gen ^ prod;
         end
         CELL_ENCODE: begin
            parity_in = nb_parity ^ prod;
         end
         CELL_SHIFT: begin
            parity_in = nb_parity;
         end
         default: begin
            parity_in = parity_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parity_ff <= '0;
      end else begin
         parity_ff <= parity_in;
      end
   end

   always_ff @(posedge clock) begin
      gen_ff <= gen_in;
   end

   assign parity = parity_ff;
   assign gen    = gen_ff;

endmodule

// ----- rtl/core/rse_obuf.sv -----
// two-entry output skid buffer for codeword symbols
// depends on rse_pkg
`timescale 1ns / 1ps

module rse_obuf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rse_pkg::code_type push_data,
   output logic              full,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rse_pkg::code_type rsp_data
);
   import rse_pkg::*;

   code_type   mem_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic       pop;

   always_comb begin
      pop       = rsp_valid && rsp_ready;
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full      = (cnt_ff == 2'd2);
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = mem_ff[rd_ptr_ff];

endmodule

// ----- rtl/core/reed_solomon_systematic_encoder.sv -----
// an info symbol is registered in the output buffer before it shows on rsp
// throughput while the buffer has room: one symbol per cycle in a message;
// after the last one the 2t parity symbols shift out of the cell chain, one
// per cycle, no input taken; after reset or a config write the generator is
// rebuilt before the next message; reset is synchronous active high
// depends on rse_pkg, rse_cell, rse_obuf and the assertion macro header
`timescale 1ns / 1ps
`include "reed_solomon_systematic_encoder_macros.svh"

module reed_solomon_systematic_encoder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  rse_pkg::sym_type                  req_info_symbol,
   input  logic                              req_info_last,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output rse_pkg::sym_type                  rsp_code_symbol,
   output logic                              rsp_code_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rse_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rse_pkg::CSR_DATA_W-1:0]    csr_data
);
   import rse_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_BUILD = 4'b0010,
      ST_BUSY  = 4'b0100,
      ST_DRAIN = 4'b1000
   } enc_state_type;

   localparam logic [CNT_BITS-1:0] CNT_ONE = CNT_BITS'(1);

   function automatic logic [CNT_BITS-1:0] par_len(logic [CAP_W-1:0] cap);
      logic [CNT_BITS-1:0] t;
      if (cap == '0) begin
         t = CNT_ONE;
      end else if (int'(cap) > T_MAX) begin
         t = CNT_BITS'(T_MAX);
      end else begin
         t = CNT_BITS'(cap);
      end
      return {t[CNT_BITS-2:0], 1'b0};
   endfunction

   enc_state_type       state_ff;
   enc_state_type       state_in;
   logic                dirty_ff;
   logic                dirty_in;
   logic [CAP_W-1:0]    ecc_ff;
   logic [CAP_W-1:0]    ecc_in;
   sym_type             poly_ff;
   sym_type             poly_in;
   logic [CNT_BITS-1:0] n_ff;
   logic [CNT_BITS-1:0] n_in;
   logic [CNT_BITS-1:0] cnt_ff;
   logic [CNT_BITS-1:0] cnt_in;
   sym_type             root_ff;
   sym_type             root_in;

   logic                accept;
   logic                obuf_full;
   logic                push;
   code_type            push_data;
   code_type            rsp_data;
   logic [CNT_BITS-1:0] n_new;
   cell_ctrl_type       ctrl;
   sym_type             par_w [NPAR+1];
   sym_type             gen_w [NPAR+1];
   logic                par_any;

   assign accept    = req_valid && req_ready;
   assign req_ready = !obuf_full &&
                      ((state_ff == ST_IDLE && !dirty_ff) || state_ff == ST_BUSY);
   assign csr_ready = 1'b1;
   assign n_new     = par_len(ecc_ff);

   // config registers
   always_comb begin
      ecc_in  = ecc_ff;
      poly_in = poly_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ECC_CAP:    ecc_in  = csr_data[CAP_W-1:0];
            CSR_FIELD_POLY: poly_in = SYM_BITS'(csr_data);
            default:        ecc_in  = ecc_ff;
         endcase
      end
   end

   // control sequencer
   always_comb begin
      state_in         = state_ff;
      n_in             = n_ff;
      cnt_in           = cnt_ff;
      root_in          = root_ff;
      dirty_in         = dirty_ff;
      push             = 1'b0;
      push_data.symbol = req_info_symbol;
      push_data.last   = 1'b0;
      ctrl.op          = CELL_HOLD;
      ctrl.fb          = req_info_symbol ^ par_w[0];
      ctrl.root        = root_ff;
      ctrl.poly        = poly_ff;
      case (state_ff)
         ST_IDLE, ST_BUSY: begin
            if (state_ff == ST_IDLE && dirty_ff) begin
               ctrl.op  = CELL_INIT;
               state_in = ST_BUILD;
               n_in     = n_new;
               cnt_in   = '0;
               root_in  = SYM_BITS'(2);
               dirty_in = 1'b0;
            end else if (accept) begin
               ctrl.op = CELL_ENCODE;
               push    = 1'b1;
               if (req_info_last) begin
                  state_in = ST_DRAIN;
                  cnt_in   = n_ff;
               end else begin
                  state_in = ST_BUSY;
               end
            end
         end
         ST_BUILD: begin
            ctrl.op = CELL_STEP;
            root_in = gf_xtime(root_ff, poly_ff);
            cnt_in  = cnt_ff + CNT_ONE;
            if (cnt_ff == n_ff - CNT_ONE) begin
               state_in = ST_IDLE;
            end
         end
         ST_DRAIN: begin
            if (!obuf_full) begin
               ctrl.op          = CELL_SHIFT;
               push             = 1'b1;
               push_data.symbol = par_w[0];
               push_data.last   = (cnt_ff == CNT_ONE);
               cnt_in           = cnt_ff - CNT_ONE;
               if (cnt_ff == CNT_ONE) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_valid && (csr_index == CSR_ECC_CAP || csr_index == CSR_FIELD_POLY)) begin
         dirty_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         dirty_ff <= 1'b1;
         ecc_ff   <= CAP_W'(8);
         poly_ff  <= SYM_BITS'(29);
         n_ff     <= '0;
         cnt_ff   <= '0;
         root_ff  <= '0;
      end else begin
         state_ff <= state_in;
         dirty_ff <= dirty_in;
         ecc_ff   <= ecc_in;
         poly_ff  <= poly_in;
         n_ff     <= n_in;
         cnt_ff   <= cnt_in;
         root_ff  <= root_in;
      end
   end

   // parity cell chain, cell 0 holds the highest degree term
   assign par_w[NPAR] = '0;
   assign gen_w[NPAR] = '0;

   for (genvar k = 0; k < NPAR; k++) begin : g_cell
      rse_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .init_one  (CNT_BITS'(k) == n_new - CNT_ONE),
         .nb_parity (par_w[k+1]),
         .nb_gen    (gen_w[k+1]),
         .parity    (par_w[k]),
         .gen       (gen_w[k])
      );
   end

   always_comb begin
      par_any = 1'b0;
      for (int k = 0; k < NPAR; k++) begin
         par_any = par_any | (|par_w[k]);
      end
   end

   rse_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (obuf_full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_code_symbol = rsp_data.symbol;
   assign rsp_code_last   = rsp_data.last;

   `RSE_ASSERT_SAME(a_accept_state, clock, reset, accept, state_ff == ST_IDLE || state_ff == ST_BUSY)
   `RSE_ASSERT_NEXT(a_last_drains, clock, reset, accept && req_info_last, state_ff == ST_DRAIN)
   `RSE_ASSERT_NEXT(a_drain_clears, clock, reset, state_ff == ST_DRAIN && push && cnt_ff == CNT_ONE, !par_any)
   `RSE_ASSERT_SAME(a_no_overflow, clock, reset, push, !obuf_full)

endmodule
